[src/b2da_pkg.sv]
// Shared constants and types for the binary to decimal ASCII converter.
package b2da_pkg;

  // Default number of binary bits converted per value
  localparam int VALUE_WIDTH_DEF = 32;

  // Width of one BCD digit held by a cell
  localparam int BCD_W = 4;

  // Output character width and the code of '0'
  localparam int CHAR_W = 6;
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  // Digit threshold for the add-3 correction of shift-and-add-3 conversion
  localparam logic [BCD_W-1:0] DABBLE_LIMIT = 4'd5;
  localparam logic [BCD_W-1:0] DABBLE_ADD   = 4'd3;

  // Per-cycle command broadcast along the row of digit cells
  typedef struct packed {
    logic clear;  // zero the digit ahead of a new value
    logic conv;   // correct and shift one binary bit in
    logic emit;   // move digits one place towards the top
  } cell_ctrl_t;

endpackage

[src/b2da_cell.sv]
// One BCD digit cell of the shift-and-add-3 conversion row.
module b2da_cell
  import b2da_pkg::*;
(
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  logic             bit_in,    // carry from the lower cell, or value MSB
  input  logic [BCD_W-1:0] digit_in,  // digit of the lower cell during output
  output logic             carry_out,
  output logic [BCD_W-1:0] digit
);

  logic [BCD_W-1:0] adj;

  // Add 3 when the digit is 5 or more so the shift lands in range
  assign adj       = (digit >= DABBLE_LIMIT) ? digit + DABBLE_ADD : digit;
  assign carry_out = adj[BCD_W-1];

  // Digit register
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      digit <= '0;
    end else if (ctrl.conv) begin
      digit <= {adj[BCD_W-2:0], bit_in};
    end else if (ctrl.emit) begin
      digit <= digit_in;
    end
  end

endmodule

[src/binary_to_decimal_ascii_core.sv]
// Top level of the binary to decimal ASCII converter.
//
// Each value on the slave stream is converted to decimal and sent out as ASCII
// digits, most significant first, with no leading zeros; zero gives a single
// '0'. tlast marks the final digit. Conversion runs through a row of BCD digit
// cells, one per decimal digit (NDIG, 10 at the default width), and shifts in
// one binary bit per cycle, VALUE_WIDTH bits in all (32 by default). The digits
// then move up the row one place per cycle while leading zeros are dropped, and
// one place per transaction while characters are sent. One value is buffered
// at the input, so the next value is taken while characters are still being
// sent.
module binary_to_decimal_ascii_core
  import b2da_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  localparam int TDATA_W = ((VALUE_WIDTH + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [TDATA_W-1:0] s_tdata,   // [VALUE_WIDTH-1:0] value, rest zero
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [7:0]         m_tdata,   // [5:0] digit_char, [7:6] zero
  output logic               m_tlast    // last digit of the number
);

  // Decimal digits needed for 2**VALUE_WIDTH - 1
  localparam int NDIG  = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int CNT_W = $clog2(VALUE_WIDTH);
  localparam int REM_W = $clog2(NDIG + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  state_t                 state;
  logic                   hold_valid;
  logic [VALUE_WIDTH-1:0] hold;
  logic [VALUE_WIDTH-1:0] sreg;
  logic [CNT_W-1:0]       cnt;
  logic [REM_W-1:0]       rem;
  logic                   lead;

  cell_ctrl_t             ctrl;
  logic [NDIG-1:0]        carry;
  logic [BCD_W-1:0]       digits [NDIG];
  logic [BCD_W-1:0]       top;
  logic                   last_digit;
  logic                   skip;
  logic                   out_hs;
  logic                   start;

  // Only zeros ahead of the first character sent are dropped
  assign top        = digits[NDIG-1];
  assign last_digit = (rem == REM_W'(1));
  assign skip       = (state == ST_EMIT) && lead && (top == '0) && !last_digit;
  assign start      = (state == ST_IDLE) && hold_valid;
  assign out_hs     = m_tvalid && m_tready;

  // Stream outputs
  assign s_tready = !hold_valid;
  assign m_tvalid = (state == ST_EMIT) && !skip;
  assign m_tdata  = {2'b00, ASCII_ZERO + CHAR_W'(top)};
  assign m_tlast  = last_digit;

  // Cell commands
  always_comb begin
    ctrl.clear = start;
    ctrl.conv  = (state == ST_CONV);
    ctrl.emit  = skip || (out_hs && !last_digit);
  end

  // Row of digit cells, least significant digit in cell 0
  for (genvar i = 0; i < NDIG; i++) begin : g_cell
    logic             bin;
    logic [BCD_W-1:0] din;
    if (i == 0) begin : g_first
      assign bin = sreg[VALUE_WIDTH-1];
      assign din = '0;
    end else begin : g_rest
      assign bin = carry[i-1];
      assign din = digits[i-1];
    end
    b2da_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .bit_in    (bin),
      .digit_in  (din),
      .carry_out (carry[i]),
      .digit     (digits[i])
    );
  end

  // Input buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      hold_valid <= 1'b1;
    end else if (start) begin
      hold_valid <= 1'b0;
    end
    if (s_tvalid && s_tready) begin
      hold <= s_tdata[VALUE_WIDTH-1:0];
    end
  end

  // Leading-zero flag: set for a new value, cleared by the first character
  always_ff @(posedge clk) begin
    if (rst) begin
      lead <= 1'b0;
    end else if (start) begin
      lead <= 1'b1;
    end else if (out_hs) begin
      lead <= 1'b0;
    end
  end

  // Sequencer: conversion count, output count and value shifter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      rem   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (hold_valid) begin
            state <= ST_CONV;
            cnt   <= CNT_W'(VALUE_WIDTH - 1);
          end
        end
        ST_CONV: begin
          if (cnt == '0) begin
            state <= ST_EMIT;
            rem   <= REM_W'(NDIG);
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        ST_EMIT: begin
          if (out_hs && last_digit) begin
            state <= ST_IDLE;
          end else if (ctrl.emit) begin
            rem <= rem - 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
    if (start) begin
      sreg <= hold;
    end else if (state == ST_CONV) begin
      sreg <= {sreg[VALUE_WIDTH-2:0], 1'b0};
    end
  end

  // The top cell has room for every value, so it never carries out
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CONV) |-> !carry[NDIG-1])
    else $error("top digit cell overflowed during conversion");

  // A character leaving is always a decimal digit
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (top <= 4'd9))
    else $error("digit out of decimal range");

  // The last character ends the number and frees the row
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_hs && m_tlast) |=> (state == ST_IDLE))
    else $error("row not released after last character");

  // A buffered value starts conversion at once when the row is free
  a_start: assert property (@(posedge clk) disable iff (rst)
    start |=> ((state == ST_CONV) && !hold_valid || (state == ST_CONV) && $past(s_tvalid)))
    else $error("buffered value not started");

endmodule
